FILE: hdl/ghst_pkg.sv
// Shared types and constants for the generational handle sparse-set table.
// Depends on nothing; the interfaces, the top level and the checker use it.
package ghst_pkg;

  // handle layout: generation in the high bits, slot index in the low bits
  localparam int HANDLE_BITS = 32;
  localparam int IDX_BITS    = 20;
  localparam int GEN_BITS    = 12;

  // field widths at the ports
  localparam int CMD_BITS     = 3;
  localparam int STATUS_BITS  = 3;
  localparam int TYPE_ID_BITS = 5;
  localparam int LIMIT_BITS   = 13;
  localparam int TYPES_BITS   = 6;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DAT_BITS = 13;

  // defaults for the top-level parameters
  localparam int DEF_ENTITY_CAP   = 4096;
  localparam int DEF_MAX_TYPES    = 32;
  localparam int DEF_PAYLOAD_BITS = 32;

  // register values after reset
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [TYPES_BITS-1:0] TYPES_RESET = 6'd32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENTITY_LIMIT = 8'd0,
    REG_TYPES_IN_USE = 8'd1
  } cfg_reg_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_DESTROY  = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_REMOVE   = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_IS_VALID = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_CAPACITY  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXISTS    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_CREATE,
    S_SPARSE,
    S_LOOKUP,
    S_DST_RD,
    S_DST_SP,
    S_RM_MOVE,
    S_RM_CLEAR,
    S_DST_FIN,
    S_RESULT
  } state_t;

endpackage

FILE: hdl/ghst_req_if.sv
// Command channel: valid/ready plus one command item.
// Depends on ghst_pkg for field widths.
interface ghst_req_if #(parameter int PW = ghst_pkg::DEF_PAYLOAD_BITS);
  logic                                  valid;
  logic                                  ready;
  logic [ghst_pkg::CMD_BITS-1:0]         cmd;
  logic [ghst_pkg::HANDLE_BITS-1:0]      handle;
  logic [ghst_pkg::TYPE_ID_BITS-1:0]     type_id;
  logic [PW-1:0]                         payload;

  modport source (output valid, cmd, handle, type_id, payload, input ready);
  modport sink   (input valid, cmd, handle, type_id, payload, output ready);
endinterface

FILE: hdl/ghst_rsp_if.sv
// Result channel: valid/ready plus one result item.
// Depends on ghst_pkg for field widths.
interface ghst_rsp_if #(parameter int PW = ghst_pkg::DEF_PAYLOAD_BITS);
  logic                                  valid;
  logic                                  ready;
  logic [ghst_pkg::STATUS_BITS-1:0]      status;
  logic [ghst_pkg::HANDLE_BITS-1:0]      handle_out;
  logic                                  found;
  logic [PW-1:0]                         payload_out;

  modport source (output valid, status, handle_out, found, payload_out, input ready);
  modport sink   (input valid, status, handle_out, found, payload_out, output ready);
endinterface

FILE: hdl/ghst_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ghst_pkg for field widths.
interface ghst_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ghst_pkg::CFG_IDX_BITS-1:0]     index;
  logic [ghst_pkg::CFG_DAT_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ghst_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies; instantiated for each store of the table.
module ghst_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/generational_handle_sparse_set_table.sv
// Top level of the generational handle table with per-type sparse-set pools.
// Depends on ghst_pkg, the three channel interfaces and ghst_ram.
//
//   channel | dir | carries
//   --------+-----+---------------------------------------------------
//   req     | in  | cmd, handle, type_id, payload
//   rsp     | out | status, handle_out, found, payload_out
//   cfg     | in  | index, data (entity_limit = 0, types_in_use = 1)
//
// Create, add, remove, lookup and is-valid take one step per dependent RAM read from
// transfer to result; an invalid handle or type, or a create with no free slot, gets
// its result right after decode. Destroy walks the pools of every type in use
// through the sparse RAM port. Reset or a write to either register starts a clearing
// pass over the slot, free and sparse stores, during which req.ready stays low.
// A finished result sits in the output register while the next command is taken.
module generational_handle_sparse_set_table #(
  parameter int ENTITY_CAP   = ghst_pkg::DEF_ENTITY_CAP,
  parameter int MAX_TYPES    = ghst_pkg::DEF_MAX_TYPES,
  parameter int PAYLOAD_BITS = ghst_pkg::DEF_PAYLOAD_BITS
) (
  input logic       clk,
  input logic       rst,
  ghst_req_if.sink  req,
  ghst_rsp_if.source rsp,
  ghst_cfg_if.sink  cfg
);
  import ghst_pkg::*;

  localparam int SLOTS     = ENTITY_CAP + 1;
  localparam int SLOT_BITS = $clog2(ENTITY_CAP + 1);
  localparam int DPOS_BITS = (ENTITY_CAP > 1) ? $clog2(ENTITY_CAP) : 1;
  localparam int TYPE_BITS = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int TCNT_BITS = $clog2(MAX_TYPES + 1);
  localparam int SP_AW     = TYPE_BITS + SLOT_BITS;
  localparam int SP_DEPTH  = MAX_TYPES * (2 ** SLOT_BITS);
  localparam int DN_AW     = TYPE_BITS + DPOS_BITS;
  localparam int DN_DEPTH  = MAX_TYPES * (2 ** DPOS_BITS);
  localparam int DN_W      = HANDLE_BITS + PAYLOAD_BITS;
  localparam int SL_W      = GEN_BITS + 1;
  localparam int CLR_BITS  = SP_AW + 1;
  localparam logic [SLOT_BITS-1:0] SP_EMPTY = SLOT_BITS'(ENTITY_CAP);

  // control registers
  state_t                 state, state_next;
  logic [LIMIT_BITS-1:0]  entity_limit;
  logic [TYPES_BITS-1:0]  types_in_use;
  logic [CLR_BITS-1:0]    clr_cnt;
  logic [SLOT_BITS-1:0]   free_top;
  logic [SLOT_BITS-1:0]   pool_cnt [MAX_TYPES];

  // command registers
  cmd_t                    cmd_r;
  logic [HANDLE_BITS-1:0]  h_r;
  logic [TYPE_ID_BITS-1:0] t_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [TYPE_BITS-1:0]    rt;
  logic [DPOS_BITS-1:0]    pos_r;
  logic [GEN_BITS-1:0]     gen_r;
  logic [SLOT_BITS-1:0]    slot_s;

  // result staging
  logic                    res_load;
  status_t                 res_status, res_status_n;
  logic [HANDLE_BITS-1:0]  res_hout, res_hout_n;
  logic                    res_found, res_found_n;
  logic [PAYLOAD_BITS-1:0] res_pout, res_pout_n;

  // RAM ports
  logic                  sl_we;
  logic [SLOT_BITS-1:0]  sl_waddr, sl_raddr;
  logic [SL_W-1:0]       sl_wdata, sl_rd;
  logic                  fl_we;
  logic [DPOS_BITS-1:0]  fl_waddr, fl_raddr;
  logic [SLOT_BITS-1:0]  fl_wdata, fl_rd;
  logic                  sp_we;
  logic [SP_AW-1:0]      sp_waddr, sp_raddr;
  logic [SLOT_BITS-1:0]  sp_wdata, sp_rd;
  logic                  dn_we;
  logic [DN_AW-1:0]      dn_waddr, dn_raddr;
  logic [DN_W-1:0]       dn_wdata, dn_rd;

  // derived values
  logic                  cfg_hit;
  logic [SLOT_BITS-1:0]  eff_lim;
  logic [TCNT_BITS-1:0]  eff_types;
  logic [IDX_BITS-1:0]   idx;
  logic                  idx_ok;
  logic [SLOT_BITS-1:0]  idx_slot;
  logic                  live;
  logic                  type_ok;
  logic [SLOT_BITS-1:0]  pc, pc_m1;
  logic [DPOS_BITS-1:0]  last, sp_pos;
  logic                  sp_present;
  logic                  last_type;
  logic [IDX_BITS-1:0]   midx;
  logic                  out_free;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid && cfg.ready &&
                     (cfg.index == REG_ENTITY_LIMIT || cfg.index == REG_TYPES_IN_USE);
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // effective register values
  always_comb begin
    if (entity_limit == '0) begin
      eff_lim = SLOT_BITS'(1);
    end else if (32'(entity_limit) > ENTITY_CAP) begin
      eff_lim = SLOT_BITS'(ENTITY_CAP);
    end else begin
      eff_lim = SLOT_BITS'(entity_limit);
    end
    if (32'(types_in_use) > MAX_TYPES) begin
      eff_types = TCNT_BITS'(MAX_TYPES);
    end else begin
      eff_types = TCNT_BITS'(types_in_use);
    end
  end

  // handle checks and pool bookkeeping
  assign idx        = h_r[IDX_BITS-1:0];
  assign idx_ok     = (idx != '0) && (32'(idx) <= 32'(eff_lim));
  assign idx_slot   = idx_ok ? SLOT_BITS'(idx) : '0;
  assign live       = idx_ok && sl_rd[GEN_BITS] &&
                      (sl_rd[GEN_BITS-1:0] == h_r[HANDLE_BITS-1:IDX_BITS]);
  assign type_ok    = 32'(t_r) < 32'(eff_types);
  assign pc         = pool_cnt[rt];
  assign pc_m1      = pc - 1'b1;
  assign last       = pc_m1[DPOS_BITS-1:0];
  assign sp_pos     = sp_rd[DPOS_BITS-1:0];
  assign sp_present = (sp_rd != SP_EMPTY);
  assign last_type  = (32'(rt) + 1) >= 32'(eff_types);
  assign midx       = dn_rd[PAYLOAD_BITS +: IDX_BITS];

  // read addresses
  assign sl_raddr = (state == S_DECODE) ? fl_rd : idx_slot;
  assign fl_raddr = DPOS_BITS'(free_top - 1'b1);
  assign sp_raddr = {rt, idx_slot};
  assign dn_raddr = (cmd_r == CMD_LOOKUP) ? {rt, sp_pos} : {rt, last};

  // sequencer: next state, RAM writes and result
  always_comb begin
    state_next   = state;
    sl_we        = 1'b0;
    sl_waddr     = idx_slot;
    sl_wdata     = '0;
    fl_we        = 1'b0;
    fl_waddr     = DPOS_BITS'(free_top);
    fl_wdata     = idx_slot;
    sp_we        = 1'b0;
    sp_waddr     = {rt, idx_slot};
    sp_wdata     = SP_EMPTY;
    dn_we        = 1'b0;
    dn_waddr     = {rt, DPOS_BITS'(pc)};
    dn_wdata     = {h_r, pay_r};
    res_load     = 1'b0;
    res_status_n = ST_OK;
    res_hout_n   = '0;
    res_found_n  = 1'b0;
    res_pout_n   = '0;
    case (state)
      S_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr_cnt[SP_AW-1:0];
        if (32'(clr_cnt) < SLOTS) begin
          sl_we    = 1'b1;
          sl_waddr = SLOT_BITS'(clr_cnt);
        end
        if (32'(clr_cnt) < ENTITY_CAP) begin
          fl_we    = 1'b1;
          fl_waddr = DPOS_BITS'(clr_cnt);
          fl_wdata = (32'(clr_cnt) < 32'(eff_lim)) ?
                     SLOT_BITS'(32'(eff_lim) - 32'(clr_cnt)) : '0;
        end
        if (32'(clr_cnt) == SP_DEPTH - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_DECODE;
      end
      S_DECODE: begin
        res_load   = 1'b1;
        state_next = S_RESULT;
        case (cmd_r)
          CMD_CREATE: begin
            if (free_top == '0) begin
              res_status_n = ST_CAPACITY;
            end else begin
              res_load   = 1'b0;
              state_next = S_CREATE;
            end
          end
          CMD_DESTROY: begin
            if (!live) begin
              res_status_n = ST_INVALID;
            end else begin
              res_load   = 1'b0;
              state_next = (eff_types == '0) ? S_DST_FIN : S_DST_SP;
            end
          end
          CMD_ADD, CMD_REMOVE, CMD_LOOKUP: begin
            if (!live || !type_ok) begin
              res_status_n = ST_INVALID;
            end else begin
              res_load   = 1'b0;
              state_next = S_SPARSE;
            end
          end
          CMD_IS_VALID: begin
            res_found_n = live;
          end
          default: begin
            res_status_n = ST_INVALID;
          end
        endcase
      end
      S_CREATE: begin
        sl_we      = 1'b1;
        sl_waddr   = slot_s;
        sl_wdata   = {1'b1, sl_rd[GEN_BITS-1:0]};
        res_load   = 1'b1;
        res_hout_n = {sl_rd[GEN_BITS-1:0], IDX_BITS'(slot_s)};
        state_next = S_RESULT;
      end
      S_SPARSE: begin
        case (cmd_r)
          CMD_ADD: begin
            res_load   = 1'b1;
            state_next = S_RESULT;
            if (sp_present) begin
              res_status_n = ST_EXISTS;
            end else if (32'(pc) >= ENTITY_CAP) begin
              res_status_n = ST_CAPACITY;
            end else begin
              dn_we    = 1'b1;
              sp_we    = 1'b1;
              sp_wdata = pc;
            end
          end
          CMD_LOOKUP: begin
            if (!sp_present) begin
              res_load     = 1'b1;
              res_status_n = ST_NOT_FOUND;
              state_next   = S_RESULT;
            end else begin
              state_next = S_LOOKUP;
            end
          end
          CMD_REMOVE: begin
            if (!sp_present || pc == '0) begin
              res_load     = 1'b1;
              res_status_n = ST_NOT_FOUND;
              state_next   = S_RESULT;
            end else begin
              state_next = (sp_pos == last) ? S_RM_CLEAR : S_RM_MOVE;
            end
          end
          default: begin
            res_load     = 1'b1;
            res_status_n = ST_INVALID;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_LOOKUP: begin
        res_load    = 1'b1;
        res_found_n = 1'b1;
        res_pout_n  = dn_rd[PAYLOAD_BITS-1:0];
        state_next  = S_RESULT;
      end
      S_DST_RD: begin
        state_next = S_DST_SP;
      end
      S_DST_SP: begin
        if (sp_present && pc != '0) begin
          state_next = (sp_pos == last) ? S_RM_CLEAR : S_RM_MOVE;
        end else begin
          state_next = last_type ? S_DST_FIN : S_DST_RD;
        end
      end
      S_RM_MOVE: begin
        // last dense entry fills the hole; its owner's sparse entry follows
        dn_we    = 1'b1;
        dn_waddr = {rt, pos_r};
        dn_wdata = dn_rd;
        if (32'(midx) < SLOTS) begin
          sp_we    = 1'b1;
          sp_waddr = {rt, SLOT_BITS'(midx)};
          sp_wdata = SLOT_BITS'(pos_r);
        end
        state_next = S_RM_CLEAR;
      end
      S_RM_CLEAR: begin
        sp_we = 1'b1;
        if (cmd_r == CMD_DESTROY) begin
          state_next = last_type ? S_DST_FIN : S_DST_RD;
        end else begin
          res_load   = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_DST_FIN: begin
        sl_we    = 1'b1;
        sl_wdata = {1'b0, gen_r + 1'b1};
        if (32'(free_top) < ENTITY_CAP) begin
          fl_we = 1'b1;
        end
        res_load   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      entity_limit <= LIMIT_RESET;
      types_in_use <= TYPES_RESET;
      clr_cnt      <= '0;
    end else if (cfg_hit) begin
      if (cfg.index == REG_ENTITY_LIMIT) begin
        entity_limit <= cfg.data[LIMIT_BITS-1:0];
      end else begin
        types_in_use <= cfg.data[TYPES_BITS-1:0];
      end
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // free count and pool counts
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      free_top <= '0;
      for (int i = 0; i < MAX_TYPES; i++) begin
        pool_cnt[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          free_top <= eff_lim;
        end
        S_DECODE: begin
          if (cmd_r == CMD_CREATE && free_top != '0) begin
            free_top <= free_top - 1'b1;
          end
        end
        S_SPARSE: begin
          if (cmd_r == CMD_ADD && !sp_present && 32'(pc) < ENTITY_CAP) begin
            pool_cnt[rt] <= pc + 1'b1;
          end
        end
        S_RM_CLEAR: begin
          pool_cnt[rt] <= pc_m1;
        end
        S_DST_FIN: begin
          if (32'(free_top) < ENTITY_CAP) begin
            free_top <= free_top + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_r <= cmd_t'(req.cmd);
          h_r   <= req.handle;
          t_r   <= req.type_id;
          pay_r <= req.payload;
          rt    <= (cmd_t'(req.cmd) == CMD_DESTROY) ? '0 : TYPE_BITS'(req.type_id);
        end
      end
      S_DECODE: begin
        gen_r  <= sl_rd[GEN_BITS-1:0];
        slot_s <= fl_rd;
      end
      S_SPARSE, S_DST_SP: begin
        pos_r <= sp_pos;
        if (state == S_DST_SP && !(sp_present && pc != '0) && !last_type) begin
          rt <= rt + 1'b1;
        end
      end
      S_RM_CLEAR: begin
        if (cmd_r == CMD_DESTROY && !last_type) begin
          rt <= rt + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      res_status <= res_status_n;
      res_hout   <= res_hout_n;
      res_found  <= res_found_n;
      res_pout   <= res_pout_n;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      rsp.status      <= res_status;
      rsp.handle_out  <= res_hout;
      rsp.found       <= res_found;
      rsp.payload_out <= res_pout;
    end
  end

  // stores
  ghst_ram #(.W(SL_W), .DEPTH(SLOTS), .AW(SLOT_BITS)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rd)
  );

  ghst_ram #(.W(SLOT_BITS), .DEPTH(ENTITY_CAP), .AW(DPOS_BITS)) u_free_ram (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rd)
  );

  ghst_ram #(.W(SLOT_BITS), .DEPTH(SP_DEPTH), .AW(SP_AW)) u_sparse_ram (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(sp_raddr), .rdata(sp_rd)
  );

  ghst_ram #(.W(DN_W), .DEPTH(DN_DEPTH), .AW(DN_AW)) u_dense_ram (
    .clk(clk), .we(dn_we), .waddr(dn_waddr), .wdata(dn_wdata),
    .raddr(dn_raddr), .rdata(dn_rd)
  );
endmodule

FILE: hdl/ghst_checker.sv
// Port-level checks on the handle table's command and result channels, bound to the top.
// Depends on ghst_pkg for status codes.
module ghst_checker #(
  parameter int PW = ghst_pkg::DEF_PAYLOAD_BITS
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [ghst_pkg::STATUS_BITS-1:0]     status,
  input logic [ghst_pkg::HANDLE_BITS-1:0]     handle_out,
  input logic                                 found,
  input logic [PW-1:0]                        payload_out
);
  import ghst_pkg::*;

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the table works on one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // a found flag only comes with success
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK)
    else $error("found set on failing command");

  // payload and handle are zero unless produced
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found || payload_out == '0) &&
                  (status == ST_OK || handle_out == '0))
    else $error("stray payload or handle");
endmodule

bind generational_handle_sparse_set_table ghst_checker #(.PW(PAYLOAD_BITS)) u_ghst_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .status(rsp.status), .handle_out(rsp.handle_out),
  .found(rsp.found), .payload_out(rsp.payload_out)
);
